[src/dupfh_pkg.sv]
// ----------------------------------------------------------------------------
// dupfh_pkg
// Shared types, codes and defaults for the dual uart poll frame handler.
// ----------------------------------------------------------------------------
package dupfh_pkg;

  localparam int DEF_TIME_BUF_LEN = 16;
  localparam int DEF_CALL_BUF_LEN = 64;
  localparam int DEF_CARD_BUF_LEN = 256;

  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  STATION_ADDRESS_RST   = 8'd1;
  localparam logic [15:0] TIMEOUT_THRESHOLD_RST = 16'd1000;

  localparam logic       CFG_STATION_ADDRESS   = 1'b0;
  localparam logic       CFG_TIMEOUT_THRESHOLD = 1'b1;

  localparam logic [1:0] KIND_UPSTREAM   = 2'd0;
  localparam logic [1:0] KIND_DOWNSTREAM = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;

  localparam logic [7:0] CMD_MASK    = 8'h82;
  localparam logic [7:0] CMD_PATTERN = 8'h80;
  localparam logic [7:0] CMD_POLL    = 8'h80;
  localparam logic [7:0] CMD_SYNC    = 8'h81;
  localparam logic [7:0] CMD_CALL    = 8'h84;
  localparam logic [7:0] CMD_DUMP    = 8'h85;
  localparam logic [7:0] FRAME_BEGIN = 8'hF0;
  localparam logic [7:0] FRAME_END   = 8'hFE;
  localparam logic [7:0] BROADCAST   = 8'h01;

  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_SEND_REQ   = 4'd1;
  localparam logic [3:0] ACT_TIME_BYTE  = 4'd2;
  localparam logic [3:0] ACT_TIME_END   = 4'd3;
  localparam logic [3:0] ACT_CALL_BYTE  = 4'd4;
  localparam logic [3:0] ACT_CALL_END   = 4'd5;
  localparam logic [3:0] ACT_CARD_BYTE  = 4'd6;
  localparam logic [3:0] ACT_CARDS_RPT  = 4'd7;
  localparam logic [3:0] ACT_CARDS_KEEP = 4'd8;
  localparam logic [3:0] ACT_DUMP       = 4'd9;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] data_byte;
    logic [8:0] frame_count;
    logic       overflow;
  } result_t;

endpackage

[src/dupfh_stream_if.sv]
// ----------------------------------------------------------------------------
// dupfh_in_if / dupfh_out_if
// Valid/ready channels for received items and for results.
// ----------------------------------------------------------------------------
interface dupfh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface dupfh_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] data_byte;
  logic [8:0] frame_count;
  logic       overflow;

  modport source (output valid, output action, output data_byte, output frame_count,
                  output overflow, input ready);
  modport sink   (input valid, input action, input data_byte, input frame_count,
                  input overflow, output ready);
endinterface

[src/dupfh_engine.sv]
// ----------------------------------------------------------------------------
// dupfh_engine
// Protocol state, configuration registers and the per-item result logic.
// ----------------------------------------------------------------------------
module dupfh_engine
  import dupfh_pkg::*;
#(
  parameter int TIME_BUF_LEN = DEF_TIME_BUF_LEN,
  parameter int CALL_BUF_LEN = DEF_CALL_BUF_LEN,
  parameter int CARD_BUF_LEN = DEF_CARD_BUF_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            kind,
  input  logic [7:0]            rx_byte,
  output result_t               result
);

  localparam int TW = $clog2(TIME_BUF_LEN + 1);
  localparam int LW = $clog2(CALL_BUF_LEN + 1);
  localparam int KW = $clog2(CARD_BUF_LEN + 1);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_WAIT_ADDR = 4'd1;
  localparam logic [3:0] PH_POLLED    = 4'd2;
  localparam logic [3:0] PH_SYNC_WAIT = 4'd3;
  localparam logic [3:0] PH_SYNC_DATA = 4'd4;
  localparam logic [3:0] PH_CALL_WAIT = 4'd5;
  localparam logic [3:0] PH_CALL_DATA = 4'd6;
  localparam logic [3:0] PH_TIMEOUT   = 4'd7;
  localparam logic [3:0] PH_DUMP_ADDR = 4'd8;

  logic [7:0]    station_address;
  logic [15:0]   timeout_threshold;
  logic [3:0]    up_phase, up_phase_next;
  logic          dn_phase, dn_phase_next;
  logic [TW-1:0] time_fill, time_fill_next;
  logic [LW-1:0] call_fill, call_fill_next;
  logic [KW-1:0] card_fill, card_fill_next;
  logic          card_ovf, card_ovf_next;
  logic [15:0]   tick_count, tick_count_next;
  logic [15:0]   tick_inc;

  assign tick_inc = tick_count + 16'd1;

  always_comb begin
    up_phase_next   = up_phase;
    dn_phase_next   = dn_phase;
    time_fill_next  = time_fill;
    call_fill_next  = call_fill;
    card_fill_next  = card_fill;
    card_ovf_next   = card_ovf;
    tick_count_next = tick_count;
    result          = '0;
    case (kind)
      KIND_UPSTREAM: begin
        if ((rx_byte & CMD_MASK) == CMD_PATTERN) begin
          if (rx_byte == CMD_POLL) begin
            up_phase_next   = PH_WAIT_ADDR;
            tick_count_next = '0;
          end else if (rx_byte == CMD_SYNC) begin
            up_phase_next = PH_SYNC_WAIT;
          end else if (rx_byte == CMD_CALL) begin
            up_phase_next = PH_CALL_WAIT;
          end else if (rx_byte == CMD_DUMP) begin
            up_phase_next = PH_DUMP_ADDR;
          end
        end else begin
          unique case (up_phase)
            PH_WAIT_ADDR: begin
              if (station_address != 8'd0 && rx_byte == station_address - 8'd1) begin
                up_phase_next    = PH_POLLED;
                result.action    = ACT_SEND_REQ;
                result.data_byte = FRAME_END;
              end else begin
                up_phase_next = PH_IDLE;
              end
            end
            PH_SYNC_WAIT: begin
              if (rx_byte == BROADCAST) begin
                up_phase_next  = PH_SYNC_DATA;
                time_fill_next = '0;
              end
            end
            PH_SYNC_DATA: begin
              if (rx_byte == FRAME_END || time_fill >= TW'(TIME_BUF_LEN)) begin
                result.action      = ACT_TIME_END;
                result.frame_count = 9'(time_fill);
                up_phase_next      = PH_IDLE;
              end else begin
                time_fill_next   = time_fill + TW'(1);
                result.action    = ACT_TIME_BYTE;
                result.data_byte = rx_byte;
              end
            end
            PH_CALL_WAIT: begin
              if (rx_byte == BROADCAST) begin
                up_phase_next  = PH_CALL_DATA;
                call_fill_next = '0;
              end
            end
            PH_CALL_DATA: begin
              if (rx_byte == FRAME_END || call_fill >= LW'(CALL_BUF_LEN)) begin
                result.action      = ACT_CALL_END;
                result.frame_count = 9'(call_fill);
                up_phase_next      = PH_IDLE;
              end else begin
                call_fill_next   = call_fill + LW'(1);
                result.action    = ACT_CALL_BYTE;
                result.data_byte = rx_byte;
              end
            end
            PH_DUMP_ADDR: begin
              if (rx_byte == BROADCAST) begin
                result.action = ACT_DUMP;
                up_phase_next  = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_DOWNSTREAM: begin
        if (up_phase == PH_POLLED || up_phase == PH_TIMEOUT) begin
          if (!dn_phase) begin
            if (rx_byte == FRAME_BEGIN) begin
              dn_phase_next  = 1'b1;
              card_fill_next = '0;
              card_ovf_next  = 1'b0;
            end
          end else if (rx_byte == FRAME_END) begin
            result.action      = (up_phase == PH_POLLED) ? ACT_CARDS_RPT : ACT_CARDS_KEEP;
            result.frame_count = 9'(card_fill);
            result.overflow    = card_ovf;
            up_phase_next      = PH_IDLE;
            dn_phase_next      = 1'b0;
          end else if (card_fill < KW'(CARD_BUF_LEN)) begin
            card_fill_next   = card_fill + KW'(1);
            result.action    = ACT_CARD_BYTE;
            result.data_byte = rx_byte;
          end else begin
            card_ovf_next   = 1'b1;
            result.overflow = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        if (tick_inc > timeout_threshold) begin
          tick_count_next  = '0;
          up_phase_next    = PH_TIMEOUT;
          result.action    = ACT_SEND_REQ;
          result.data_byte = FRAME_END;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address   <= STATION_ADDRESS_RST;
      timeout_threshold <= TIMEOUT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATION_ADDRESS:   station_address   <= cfg_data[7:0];
        CFG_TIMEOUT_THRESHOLD: timeout_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_phase   <= PH_IDLE;
      dn_phase   <= 1'b0;
      time_fill  <= '0;
      call_fill  <= '0;
      card_fill  <= '0;
      card_ovf   <= 1'b0;
      tick_count <= '0;
    end else if (accept) begin
      up_phase   <= up_phase_next;
      dn_phase   <= dn_phase_next;
      time_fill  <= time_fill_next;
      call_fill  <= call_fill_next;
      card_fill  <= card_fill_next;
      card_ovf   <= card_ovf_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

[src/dupfh_out_reg.sv]
// ----------------------------------------------------------------------------
// dupfh_out_reg
// Result register; takes a new result whenever the held one leaves.
// ----------------------------------------------------------------------------
module dupfh_out_reg
  import dupfh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t result_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

[src/dual_uart_poll_frame_handler.sv]
// ----------------------------------------------------------------------------
// dual_uart_poll_frame_handler
// Polling-bus and reader-link protocol engine of a card-reader station.
//
//   channel  | dir | payload                                   | transfer
//   in_ch    | in  | kind, rx_byte                             | valid & ready
//   out_ch   | out | action, data_byte, frame_count, overflow  | valid & ready
//   cfg      | in  | cfg_index, cfg_data                       | cfg_we
//
// one item accepted per cycle while in_ch.ready is high; its result appears in the
// following cycle from the result register, which is the only stage between the two channels.
// rst is synchronous: phases, fills and tick count clear, registers reload.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// ----------------------------------------------------------------------------
module dual_uart_poll_frame_handler
  import dupfh_pkg::*;
#(
  parameter int TIME_BUF_LEN = DEF_TIME_BUF_LEN,
  parameter int CALL_BUF_LEN = DEF_CALL_BUF_LEN,
  parameter int CARD_BUF_LEN = DEF_CARD_BUF_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dupfh_in_if.sink              in_ch,
  dupfh_out_if.source           out_ch
);

  logic    can_load;
  logic    in_xfer;
  result_t res_comb;
  result_t res_q;

  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && can_load;

  dupfh_engine #(
    .TIME_BUF_LEN (TIME_BUF_LEN),
    .CALL_BUF_LEN (CALL_BUF_LEN),
    .CARD_BUF_LEN (CARD_BUF_LEN)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_xfer),
    .kind      (in_ch.kind),
    .rx_byte   (in_ch.rx_byte),
    .result    (res_comb)
  );

  dupfh_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_xfer),
    .result_in  (res_comb),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .can_load   (can_load),
    .result_out (res_q)
  );

  assign out_ch.action      = res_q.action;
  assign out_ch.data_byte   = res_q.data_byte;
  assign out_ch.frame_count = res_q.frame_count;
  assign out_ch.overflow    = res_q.overflow;

  // every transfer in yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_ch.valid)
    else $error("result missing after input transfer");

  a_time_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.action == ACT_TIME_END) |->
      (out_ch.frame_count <= 9'(TIME_BUF_LEN)))
    else $error("time frame count beyond buffer");

  a_call_count: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.action == ACT_CALL_END) |->
      (out_ch.frame_count <= 9'(CALL_BUF_LEN)))
    else $error("call frame count beyond buffer");

  a_request_byte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.action == ACT_SEND_REQ) |->
      (out_ch.data_byte == FRAME_END && out_ch.frame_count == 9'd0))
    else $error("downstream request with wrong payload");

endmodule
